// ----- hw/rtl/utcofs_pkg.sv -----
// shared types and constants for the utc offset string parser
// no dependencies; used by utcofs_parse and utc_offset_string_to_seconds_core
package utcofs_pkg;

  typedef enum logic [2:0] {
    PhU     = 3'd0,
    PhT     = 3'd1,
    PhC     = 3'd2,
    PhSign  = 3'd3,
    PhHours = 3'd4,
    PhColon = 3'd5,
    PhMins  = 3'd6,
    PhDone  = 3'd7
  } parse_phase_e;

  localparam logic [7:0] CharU     = 8'h55;
  localparam logic [7:0] CharT     = 8'h54;
  localparam logic [7:0] CharC     = 8'h43;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharColon = 8'h3A;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;

  localparam logic [1:0] MaxDigits = 2'd2;

  localparam int unsigned ValueWidth  = 7;
  localparam int unsigned OffsetWidth = 20;
  localparam int unsigned MagWidth    = 19;

  localparam logic [11:0] SecPerHour = 12'd3600;
  localparam logic [5:0]  SecPerMin  = 6'd60;

  typedef struct packed {
    logic                  negative;
    logic [ValueWidth-1:0] hours;
    logic [ValueWidth-1:0] minutes;
  } parse_result_t;

endpackage

// ----- hw/rtl/utc_offset_string_to_seconds_core.sv -----
// utc offset string to seconds converter, top level
// depends on utcofs_pkg and utcofs_parse
//
// input stream: one ascii character per transfer on s_axis_tdata, s_axis_tlast
// marks the last character of an offset string such as UTC+10:30.
// output stream: one signed offset in seconds per string on m_axis_tdata,
// 20 bits two's complement, upper 4 bits zero.
// throughput: one character per cycle while s_axis_tready is high; the parser
// updates its state in the cycle the character is taken.
// pipeline: the sign, hours and minutes parsed up to the last character are
// registered in the snapshot stage; the hours*3600 + minutes*60 multiply-add
// and the negation are then registered in the output stage.
// reset: the parser returns to expecting the letter U, both pipeline stages
// empty. the parser also returns there after each last character.
// stall: when m_axis_tready is low the result holds; the snapshot stage
// still takes one more string, then s_axis_tready drops until the output
// drains.
module utc_offset_string_to_seconds_core import utcofs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] text_char
  input  logic        s_axis_tlast,   // is_final
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // [19:0] offset_seconds
);

  parse_result_t          parse_res;
  parse_result_t          snap_q;
  logic                   snap_valid_q;
  logic                   out_valid_q;
  logic [OffsetWidth-1:0] out_data_q, out_data_d;
  logic [MagWidth-1:0]    mag;
  logic                   out_free, snap_free, in_xfer;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign snap_free     = !snap_valid_q || out_free;
  assign s_axis_tready = snap_free;
  assign in_xfer       = s_axis_tvalid && snap_free;

  utcofs_parse u_parse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .take_i   (in_xfer),
    .char_i   (s_axis_tdata),
    .final_i  (s_axis_tlast),
    .result_o (parse_res)
  );

  always_comb begin
    mag = MagWidth'(snap_q.hours) * MagWidth'(SecPerHour)
        + MagWidth'(snap_q.minutes) * MagWidth'(SecPerMin);
    out_data_d = snap_q.negative ? OffsetWidth'(-{1'b0, mag}) : OffsetWidth'(mag);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (snap_free) snap_valid_q <= in_xfer && s_axis_tlast;
      if (out_free)  out_valid_q  <= snap_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (snap_free && in_xfer && s_axis_tlast) snap_q <= parse_res;
    if (out_free && snap_valid_q) out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, out_data_q};

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ($signed(out_data_q) >= -20'sd362340 &&
                     $signed(out_data_q) <= 20'sd362340))
    else $error("offset out of range");

  a_ready_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (snap_valid_q && out_valid_q && !m_axis_tready))
    else $error("input stalled without a full pipeline");

  a_snap_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (snap_valid_q && !out_free) |=> (snap_valid_q && $stable(snap_q)))
    else $error("snapshot lost while output stalled");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_free && !snap_valid_q) |=> !out_valid_q)
    else $error("result invented");

endmodule

// ----- hw/rtl/utcofs_parse.sv -----
// character parser: phase state, hour and minute accumulation
// depends on utcofs_pkg
module utcofs_parse import utcofs_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          take_i,
  input  logic [7:0]    char_i,
  input  logic          final_i,
  output parse_result_t result_o
);

  parse_phase_e          phase_q, phase_d;
  logic [1:0]            cnt_q, cnt_d, cnt_inc;
  logic [ValueWidth-1:0] hour_q, hour_d, min_q, min_d;
  logic                  neg_q, neg_d;
  logic                  search, is_digit;
  logic [3:0]            digit_val;
  logic [10:0]           acc_wide;

  assign is_digit  = (char_i >= CharZero) && (char_i <= CharNine);
  assign digit_val = is_digit ? 4'(char_i - CharZero) : 4'd0;

  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    hour_d   = hour_q;
    min_d    = min_q;
    neg_d    = neg_q;
    search   = 1'b1;
    cnt_inc  = 2'd0;
    acc_wide = 11'd0;
    if (search && phase_q <= PhU) begin
      phase_d = PhT;
      if (char_i == CharU) search = 1'b0;
    end
    if (search && phase_q <= PhT) begin
      phase_d = PhC;
      if (char_i == CharT) search = 1'b0;
    end
    if (search && phase_q <= PhC) begin
      phase_d = PhSign;
      if (char_i == CharC) search = 1'b0;
    end
    if (search && phase_q <= PhSign) begin
      phase_d = PhHours;
      cnt_d   = 2'd0;
      if (char_i == CharPlus) begin
        neg_d  = 1'b0;
        search = 1'b0;
      end else if (char_i == CharMinus) begin
        neg_d  = 1'b1;
        search = 1'b0;
      end
    end
    if (search && phase_q <= PhHours) begin
      if (is_digit) begin
        acc_wide = 11'(hour_q) * 11'd10 + 11'(digit_val);
        hour_d   = acc_wide[ValueWidth-1:0];
        cnt_inc  = cnt_d + 2'd1;
        if (cnt_inc >= MaxDigits) begin
          phase_d = PhColon;
          cnt_d   = 2'd0;
        end else begin
          phase_d = PhHours;
          cnt_d   = cnt_inc;
        end
        search = 1'b0;
      end else begin
        phase_d = PhColon;
        cnt_d   = 2'd0;
      end
    end
    if (search && phase_q <= PhColon) begin
      if (char_i == CharColon) begin
        phase_d = PhMins;
        cnt_d   = 2'd0;
        search  = 1'b0;
      end else begin
        // no colon: the parse ends here, minutes are never tried
        phase_d = PhDone;
        search  = 1'b0;
      end
    end
    if (search && phase_q <= PhMins) begin
      if (is_digit) begin
        acc_wide = 11'(min_q) * 11'd10 + 11'(digit_val);
        min_d    = acc_wide[ValueWidth-1:0];
        cnt_inc  = cnt_d + 2'd1;
        if (cnt_inc >= MaxDigits) begin
          phase_d = PhDone;
          cnt_d   = 2'd0;
        end else begin
          cnt_d = cnt_inc;
        end
        search = 1'b0;
      end else begin
        phase_d = PhDone;
      end
    end
  end

  assign result_o = '{negative: neg_d, hours: hour_d, minutes: min_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhU;
      cnt_q   <= 2'd0;
      hour_q  <= '0;
      min_q   <= '0;
      neg_q   <= 1'b0;
    end else if (take_i) begin
      if (final_i) begin
        phase_q <= PhU;
        cnt_q   <= 2'd0;
        hour_q  <= '0;
        min_q   <= '0;
        neg_q   <= 1'b0;
      end else begin
        phase_q <= phase_d;
        cnt_q   <= cnt_d;
        hour_q  <= hour_d;
        min_q   <= min_d;
        neg_q   <= neg_d;
      end
    end
  end

endmodule
